[src/hfd_pkg.sv]
package hfd_pkg;

  // Longest text line that is kept; a further character drops the line.
  localparam int unsigned LINE_CHARS = 31;
  localparam int unsigned LINE_CNT_W = $clog2(LINE_CHARS + 1);

  localparam int unsigned NUM_KW = 3;

  localparam logic [7:0] START_BYTE = 8'hFE;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_LC_A  = 8'h61;
  localparam logic [7:0] CHAR_LC_Z  = 8'h7A;
  localparam logic [7:0] CASE_DELTA = 8'h20;

  localparam logic OP_BYTE   = 1'b0;
  localparam logic OP_RESYNC = 1'b1;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_FRAME   = 2'd1;
  localparam logic [1:0] KIND_TEXT    = 2'd2;

  localparam logic [1:0] CMD_VERSION = 2'd0;
  localparam logic [1:0] CMD_PING    = 2'd1;
  localparam logic [1:0] CMD_SCAN    = 2'd2;
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;

  // Keyword text, upper case, one row per command code.
  localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
    '{8'h56, 8'h45, 8'h52, 8'h53, 8'h49, 8'h4F, 8'h4E, 8'h00},  // VERSION
    '{8'h50, 8'h49, 8'h4E, 8'h47, 8'h00, 8'h00, 8'h00, 8'h00},  // PING
    '{8'h53, 8'h43, 8'h41, 8'h4E, 8'h00, 8'h00, 8'h00, 8'h00}   // SCAN
  };
  localparam logic [3:0] KW_LEN [NUM_KW] = '{4'd7, 4'd4, 4'd4};

  typedef struct packed {
    logic       opcode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] payload_value;
    logic [7:0] target_bus;
    logic       frame_ok;
    logic       expects_reply;
    logic [7:0] frame_length;
    logic [1:0] command_code;
  } out_item_t;

endpackage

[src/hfd_stream_if.sv]
interface hfd_in_if;
  logic               valid;
  logic               ready;
  hfd_pkg::in_item_t  item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface hfd_out_if;
  logic               valid;
  logic               ready;
  hfd_pkg::out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

[src/host_frame_deframer_top.sv]
// Host byte deframer with a text command line decoder on the same stream.
// in_i carries one host word per handshake: opcode selects a received byte
// or a resync that returns framing to idle and drops any partial frame or
// text line. out_o carries at most one result word per input word: a
// payload byte, a frame end (ok, length, reply expected) or a recognized
// text command (VERSION, PING, SCAN or unknown).
// A result appears on out_o in the cycle after its input word is accepted.
// Throughput: one input word per cycle unless a result stalls; the frame
// and line state updates on accept, so consecutive words need no gap.
// A single output register decouples the sides: in_i.ready is high while
// that register is empty or is being drained in the same cycle. When the
// receiver stalls with a result pending, in_i.ready drops and input holds
// until out_o.ready returns. Words that produce no result still load the
// output register: its data clears and out_o.valid stays low.
// Reset (rst_ni low, asynchronous): framing returns to idle, all counters
// and sums clear, the keyword match bits set, and out_o.valid drops.
module host_frame_deframer_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  hfd_in_if.sink    in_i,
  hfd_out_if.source out_o
);

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_BUS     = 3'd1,
    PH_LEN     = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CKSUM   = 3'd4,
    PH_LINE    = 3'd5
  } phase_e;

  localparam int unsigned CW = hfd_pkg::LINE_CNT_W;

  phase_e                      phase_q, phase_d;
  logic [7:0]                  bus_q, bus_d;
  logic [7:0]                  len_q, len_d;
  logic [7:0]                  pcnt_q, pcnt_d;
  logic [7:0]                  sum_q, sum_d;
  logic                        bcast_q, bcast_d;
  logic [CW-1:0]               line_cnt_q, line_cnt_d;
  logic [CW-1:0]               cmp_len_q, cmp_len_d;
  logic                        nul_q, nul_d;
  logic [hfd_pkg::NUM_KW-1:0]  match_q, match_d;
  logic                        out_valid_q, out_valid_d;
  hfd_pkg::out_item_t          out_q, out_d;

  logic                        in_fire;
  logic [7:0]                  b;
  logic                        is_term;

  // Character intake for the text line, shared by line open and line continue.
  logic                        tk_start;
  logic [CW-1:0]               tk_cnt_base, tk_cmp_base;
  logic                        tk_nul_base;
  logic [hfd_pkg::NUM_KW-1:0]  tk_match_base;
  logic [CW-1:0]               tk_cnt, tk_cmp;
  logic                        tk_nul;
  logic [hfd_pkg::NUM_KW-1:0]  tk_match;
  logic [7:0]                  up;
  logic [7:0]                  pcnt_inc;
  logic [1:0]                  cmd;

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_fire     = in_i.valid && in_i.ready;
  assign b           = in_i.item.data_byte;
  assign is_term     = (b == hfd_pkg::CHAR_CR) || (b == hfd_pkg::CHAR_LF);
  assign out_o.valid = out_valid_q;
  assign out_o.item  = out_q;
  assign pcnt_inc    = pcnt_q + 8'd1;

  assign up = ((b >= hfd_pkg::CHAR_LC_A) && (b <= hfd_pkg::CHAR_LC_Z)) ?
              (b - hfd_pkg::CASE_DELTA) : b;

  // Open a fresh line outside the line phase; else continue the current one.
  assign tk_start      = (phase_q != PH_LINE);
  assign tk_cnt_base   = tk_start ? '0 : line_cnt_q;
  assign tk_cmp_base   = tk_start ? '0 : cmp_len_q;
  assign tk_nul_base   = tk_start ? 1'b0 : nul_q;
  assign tk_match_base = tk_start ? '1 : match_q;

  always_comb begin
    tk_cnt   = tk_cnt_base + CW'(1);
    tk_cmp   = tk_cmp_base;
    tk_nul   = tk_nul_base;
    tk_match = tk_match_base;
    if (!tk_nul_base) begin
      if (b == hfd_pkg::CHAR_NUL) begin
        tk_nul = 1'b1;
      end else begin
        for (int k = 0; k < hfd_pkg::NUM_KW; k++) begin
          if ((tk_cmp_base >= CW'(hfd_pkg::KW_LEN[k])) ||
              (hfd_pkg::KW_TEXT[k][tk_cmp_base[2:0]] != up)) begin
            tk_match[k] = 1'b0;
          end
        end
        tk_cmp = tk_cmp_base + CW'(1);
      end
    end
  end

  // First keyword whose match bit survived and whose length was reached.
  always_comb begin
    cmd = hfd_pkg::CMD_UNKNOWN;
    for (int k = hfd_pkg::NUM_KW - 1; k >= 0; k--) begin
      if (match_q[k] && (cmp_len_q == CW'(hfd_pkg::KW_LEN[k]))) begin
        cmd = 2'(k);
      end
    end
  end

  always_comb begin
    phase_d     = phase_q;
    bus_d       = bus_q;
    len_d       = len_q;
    pcnt_d      = pcnt_q;
    sum_d       = sum_q;
    bcast_d     = bcast_q;
    line_cnt_d  = line_cnt_q;
    cmp_len_d   = cmp_len_q;
    nul_d       = nul_q;
    match_d     = match_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_o.ready;

    if (in_fire) begin
      out_d       = '0;
      out_valid_d = 1'b0;
      if (in_i.item.opcode == hfd_pkg::OP_RESYNC) begin
        phase_d = PH_IDLE;
      end else begin
        unique case (phase_q)
          PH_BUS: begin
            bus_d   = b;
            phase_d = PH_LEN;
          end
          PH_LEN: begin
            len_d   = b;
            pcnt_d  = '0;
            bcast_d = 1'b0;
            sum_d   = bus_q + b;
            phase_d = (b == 8'd0) ? PH_CKSUM : PH_PAYLOAD;
          end
          PH_PAYLOAD: begin
            if ((pcnt_q == 8'd2) && (b == hfd_pkg::START_BYTE)) begin
              bcast_d = 1'b1;
            end
            pcnt_d = pcnt_inc;
            sum_d  = sum_q + b;
            if (pcnt_inc >= len_q) begin
              phase_d = PH_CKSUM;
            end
            out_d.result_kind   = hfd_pkg::KIND_PAYLOAD;
            out_d.payload_value = b;
            out_d.target_bus    = bus_q;
            out_valid_d         = 1'b1;
          end
          PH_CKSUM: begin
            out_d.result_kind   = hfd_pkg::KIND_FRAME;
            out_d.target_bus    = bus_q;
            out_d.frame_ok      = (b == sum_q) && (bus_q <= 8'd1);
            out_d.expects_reply = !bcast_q;
            out_d.frame_length  = len_q;
            out_valid_d         = 1'b1;
            phase_d             = PH_IDLE;
          end
          PH_LINE: begin
            if (is_term) begin
              // Close the line; an empty compare (leading NUL) emits nothing.
              phase_d = PH_IDLE;
              if (cmp_len_q != '0) begin
                out_d.result_kind  = hfd_pkg::KIND_TEXT;
                out_d.command_code = cmd;
                out_valid_d        = 1'b1;
              end
            end else if (line_cnt_q < CW'(hfd_pkg::LINE_CHARS)) begin
              line_cnt_d = tk_cnt;
              cmp_len_d  = tk_cmp;
              nul_d      = tk_nul;
              match_d    = tk_match;
            end else begin
              // Overflow: drop the line and consume this byte.
              phase_d = PH_IDLE;
            end
          end
          default: begin
            if (b == hfd_pkg::START_BYTE) begin
              phase_d = PH_BUS;
            end else if (!is_term) begin
              line_cnt_d = tk_cnt;
              cmp_len_d  = tk_cmp;
              nul_d      = tk_nul;
              match_d    = tk_match;
              phase_d    = PH_LINE;
            end else begin
              phase_d = PH_IDLE;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      bus_q       <= '0;
      len_q       <= '0;
      pcnt_q      <= '0;
      sum_q       <= '0;
      bcast_q     <= 1'b0;
      line_cnt_q  <= '0;
      cmp_len_q   <= '0;
      nul_q       <= 1'b0;
      match_q     <= '1;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      bus_q       <= bus_d;
      len_q       <= len_d;
      pcnt_q      <= pcnt_d;
      sum_q       <= sum_d;
      bcast_q     <= bcast_d;
      line_cnt_q  <= line_cnt_d;
      cmp_len_q   <= cmp_len_d;
      nul_q       <= nul_d;
      match_q     <= match_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // Compared text never runs ahead of the stored character count.
  a_cmp_le_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_len_q <= line_cnt_q)
    else $error("compare length exceeds line count");

  // Once a NUL is in the line, the count is strictly ahead of the compare.
  a_nul_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_LINE) && nul_q |-> line_cnt_q > cmp_len_q)
    else $error("NUL seen without a stored NUL character");

  // The payload phase is left before the count reaches the declared length.
  a_pcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> pcnt_q < len_q)
    else $error("payload count reached length while still in payload");

  // An accepted resync always lands in idle.
  a_resync_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_i.item.opcode == hfd_pkg::OP_RESYNC) |=> phase_q == PH_IDLE)
    else $error("resync did not return to idle");

  // A pending result that is not taken blocks further input.
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |-> !in_i.ready)
    else $error("input accepted over a stalled result");

endmodule
